/* src/n_queens_solution_enumerator_top_macros.svh */
// Assertion macros used by the N-queens enumerator checker
`ifndef N_QUEENS_SOLUTION_ENUMERATOR_TOP_MACROS_SVH
`define N_QUEENS_SOLUTION_ENUMERATOR_TOP_MACROS_SVH

// Checked on every rising edge outside reset
`define NQSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included
`define NQSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/nqse_pkg.sv */
// Shared types and constants of the N-queens solution enumerator
package nqse_pkg;

  localparam int unsigned CfgW   = 5;
  localparam int unsigned ColW   = 4;
  localparam int unsigned PlcW   = 64;
  localparam int unsigned CountW = 32;

  localparam logic [CfgW-1:0] BoardSizeReset = 5'd8;

  // Request from the channel side to the search engine
  typedef struct packed {
    logic go;
    logic restart;
  } nqse_cmd_t;

  // One finished result of the search engine
  typedef struct packed {
    logic              found;
    logic [PlcW-1:0]   placement;
    logic [CountW-1:0] solution_index;
  } nqse_res_t;

endpackage

/* src/nqse_if.sv */
// Request and response channel interfaces of the N-queens enumerator
interface nqse_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface nqse_rsp_if import nqse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [PlcW-1:0]   placement;
  logic [CountW-1:0] solution_index;

  modport source (output valid, output found, output placement, output solution_index,
                  input ready);
  modport sink   (input valid, input found, input placement, input solution_index,
                  output ready);
endinterface

/* src/nqse_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data
module nqse_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/nqse_engine.sv */
// Backtracking search engine: occupancy masks, row counter and column stack in RAM
module nqse_engine import nqse_pkg::*; #(
  parameter int unsigned MAX_N = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [$clog2(MAX_N+1)-1:0] n_i,
  input  logic                       clr_i,
  input  nqse_cmd_t                  cmd_i,
  output logic                       idle_o,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output nqse_res_t                  res_o
);

  localparam int unsigned RowW  = $clog2(MAX_N + 1);
  localparam int unsigned StkAw = $clog2(MAX_N);
  localparam int unsigned DiagN = 2 * MAX_N - 1;
  localparam int unsigned DiagW = $clog2(DiagN);

  typedef enum logic [2:0] {
    StIdle,
    StTry,
    StPop,
    StCollect,
    StFinish
  } state_e;

  state_e              state_q, state_d;
  logic [RowW-1:0]     row_q, row_d;
  logic [RowW-1:0]     col_q, col_d;
  logic [RowW-1:0]     k_q, k_d;
  logic [MAX_N-1:0]    colm_q, colm_d;
  logic [DiagN-1:0]    sdm_q, sdm_d;
  logic [DiagN-1:0]    ddm_q, ddm_d;
  logic                exh_q, exh_d;
  logic                found_q, found_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic [PlcW-1:0]     plc_q, plc_d;

  logic                ram_we;
  logic [StkAw-1:0]    ram_waddr;
  logic [StkAw-1:0]    ram_wdata;
  logic [StkAw-1:0]    ram_raddr;
  logic [StkAw-1:0]    ram_rdata;

  logic [RowW-1:0]     prow;
  logic [RowW-1:0]     tg_row;
  logic [RowW-1:0]     tg_col;
  logic [StkAw-1:0]    cix;
  logic [DiagW-1:0]    sidx;
  logic [DiagW-1:0]    didx;
  logic [MAX_N-1:0]    cbit;
  logic [DiagN-1:0]    sbit;
  logic [DiagN-1:0]    dbit;
  logic                free;

  nqse_ram #(
    .Width (StkAw),
    .Depth (MAX_N)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // One queen position is either tried (TRY) or removed (POP) per cycle
  assign prow   = row_q - RowW'(1);
  assign tg_row = (state_q == StPop) ? prow : row_q;
  assign tg_col = (state_q == StPop) ? RowW'(ram_rdata) : col_q;
  assign cix    = tg_col[StkAw-1:0];
  assign sidx   = DiagW'(tg_row) + DiagW'(tg_col);
  assign didx   = DiagW'(n_i) - DiagW'(1) + DiagW'(tg_row) - DiagW'(tg_col);
  assign cbit   = MAX_N'(1) << cix;
  assign sbit   = DiagN'(1) << sidx;
  assign dbit   = DiagN'(1) << didx;
  assign free   = ((colm_q & cbit) == '0) && ((sdm_q & sbit) == '0) &&
                  ((ddm_q & dbit) == '0);

  always_comb begin
    logic [RowW-1:0]  row_e;
    logic             exh_e;
    logic [StkAw-1:0] pix;

    state_d   = state_q;
    row_d     = row_q;
    col_d     = col_q;
    k_d       = k_q;
    colm_d    = colm_q;
    sdm_d     = sdm_q;
    ddm_d     = ddm_q;
    exh_d     = exh_q;
    found_d   = found_q;
    cnt_d     = cnt_q;
    plc_d     = plc_q;
    ram_we    = 1'b0;
    ram_waddr = row_q[StkAw-1:0];
    ram_wdata = col_q[StkAw-1:0];
    ram_raddr = prow[StkAw-1:0];
    row_e     = (cmd_i.restart || clr_i) ? '0 : row_q;
    exh_e     = (cmd_i.restart || clr_i) ? 1'b0 : exh_q;
    pix       = StkAw'(k_q - RowW'(1));

    case (state_q)
      StIdle: begin
        if (clr_i || (cmd_i.go && cmd_i.restart)) begin
          colm_d = '0;
          sdm_d  = '0;
          ddm_d  = '0;
          row_d  = '0;
          exh_d  = 1'b0;
          cnt_d  = '0;
        end
        if (cmd_i.go) begin
          if (exh_e) begin
            found_d = 1'b0;
            plc_d   = '0;
            state_d = StFinish;
          end else if (row_e >= n_i) begin
            // last solution still on the board: lift the top queen first
            state_d = StPop;
          end else begin
            col_d   = '0;
            state_d = StTry;
          end
        end
      end

      StTry: begin
        if (col_q < n_i) begin
          if (free) begin
            colm_d = colm_q ^ cbit;
            sdm_d  = sdm_q ^ sbit;
            ddm_d  = ddm_q ^ dbit;
            ram_we = 1'b1;
            row_d  = row_q + RowW'(1);
            col_d  = '0;
            if (row_q + RowW'(1) >= n_i) begin
              cnt_d   = (&cnt_q) ? cnt_q : cnt_q + CountW'(1);
              k_d     = '0;
              plc_d   = '0;
              state_d = StCollect;
            end
          end else begin
            col_d = col_q + RowW'(1);
          end
        end else if (row_q == '0) begin
          exh_d   = 1'b1;
          found_d = 1'b0;
          plc_d   = '0;
          state_d = StFinish;
        end else begin
          // stack read of the row above is issued now
          state_d = StPop;
        end
      end

      StPop: begin
        colm_d  = colm_q ^ cbit;
        sdm_d   = sdm_q ^ sbit;
        ddm_d   = ddm_q ^ dbit;
        row_d   = prow;
        col_d   = RowW'(ram_rdata) + RowW'(1);
        state_d = StTry;
      end

      StCollect: begin
        // read row k, pack row k-1 that arrives from the previous read
        ram_raddr = k_q[StkAw-1:0];
        if (k_q != '0) begin
          plc_d[pix*ColW +: ColW] = ColW'(ram_rdata);
        end
        if (k_q == n_i) begin
          found_d = 1'b1;
          state_d = StFinish;
        end else begin
          k_d = k_q + RowW'(1);
        end
      end

      StFinish: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      row_q   <= '0;
      col_q   <= '0;
      k_q     <= '0;
      colm_q  <= '0;
      sdm_q   <= '0;
      ddm_q   <= '0;
      exh_q   <= 1'b0;
      found_q <= 1'b0;
      cnt_q   <= '0;
      plc_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      k_q     <= k_d;
      colm_q  <= colm_d;
      sdm_q   <= sdm_d;
      ddm_q   <= ddm_d;
      exh_q   <= exh_d;
      found_q <= found_d;
      cnt_q   <= cnt_d;
      plc_q   <= plc_d;
    end
  end

  assign idle_o               = (state_q == StIdle);
  assign res_valid_o          = (state_q == StFinish);
  assign res_o.found          = found_q;
  assign res_o.placement      = plc_q;
  assign res_o.solution_index = cnt_q;

endmodule

/* src/n_queens_solution_enumerator_top.sv */
// Sequence: TRY tests one column or places a queen, POP lifts a queen after its stack RAM
//   read, COLLECT reads the column stack out, and the result passes the output register.
// Throughput: one request at a time; the time per request is set by the number of
//   backtracking steps to the next solution, which depends on board size and position.
// Reset: asynchronous, active low; board size returns to 8 and the search to an empty
//   board. A size write in idle also restarts the search. No RAM clearing pass is needed.
module n_queens_solution_enumerator_top import nqse_pkg::*; #(
  parameter int unsigned MAX_N = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  nqse_req_if.sink        req_i,
  nqse_rsp_if.source      rsp_o
);

  localparam int unsigned RowW = $clog2(MAX_N + 1);

  logic [CfgW-1:0] board_size_q;
  logic [RowW-1:0] n_eff;
  nqse_cmd_t       cmd;
  logic            idle;
  logic            res_valid;
  logic            res_ready;
  nqse_res_t       res;
  logic            out_valid_q;
  nqse_res_t       out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_size_q <= BoardSizeReset;
    end else if (cfg_we_i) begin
      board_size_q <= cfg_wdata_i;
    end
  end

  // Clamp the board size to 1..MAX_N
  always_comb begin
    if (board_size_q == '0) begin
      n_eff = RowW'(1);
    end else if (board_size_q > CfgW'(MAX_N)) begin
      n_eff = RowW'(MAX_N);
    end else begin
      n_eff = RowW'(board_size_q);
    end
  end

  assign cmd.go      = req_i.valid && idle;
  assign cmd.restart = req_i.restart;
  assign req_i.ready = idle;

  nqse_engine #(
    .MAX_N (MAX_N)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (n_eff),
    .clr_i       (cfg_we_i),
    .cmd_i       (cmd),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: hold the result until the sink takes it
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.found          = out_q.found;
  assign rsp_o.placement      = out_q.placement;
  assign rsp_o.solution_index = out_q.solution_index;

endmodule

/* src/nqse_checker.sv */
// Port-level checker of the N-queens enumerator and its bind to the top level
`include "n_queens_solution_enumerator_top_macros.svh"

module nqse_checker import nqse_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic              rsp_found_i,
  input logic [PlcW-1:0]   rsp_placement_i,
  input logic [CountW-1:0] rsp_index_i
);

  `NQSE_ASSERT_ALWAYS(a_no_rsp_in_reset, !rst_ni |-> !rsp_valid_i, "response valid during reset")

  `NQSE_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_found_i) && $stable(rsp_placement_i) && $stable(rsp_index_i), "stalled response changed")

  `NQSE_ASSERT(a_exhausted_empty, rsp_valid_i && !rsp_found_i |-> rsp_placement_i == '0, "exhausted response carries a placement")

  `NQSE_ASSERT(a_found_counted, rsp_valid_i && rsp_found_i |-> rsp_index_i != '0, "solution reported with zero count")

endmodule

bind n_queens_solution_enumerator_top nqse_checker u_nqse_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_found_i     (rsp_o.found),
  .rsp_placement_i (rsp_o.placement),
  .rsp_index_i     (rsp_o.solution_index)
);

/* sim/tb_n_queens_solution_enumerator_top.sv */
// Self-checking testbench of the N-queens solution enumerator with its own search model
module tb_n_queens_solution_enumerator_top;
  import nqse_pkg::*;

  localparam int unsigned MaxN = 16;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;

  nqse_req_if req_if ();
  nqse_rsp_if rsp_if ();

  n_queens_solution_enumerator_top #(
    .MAX_N(MaxN)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Search model state
  logic [CfgW-1:0]   size_q;
  logic [15:0]       cols_taken;
  logic [30:0]       sums_taken;
  logic [30:0]       diffs_taken;
  logic [3:0]        col_stack [16];
  int unsigned       rows_placed;
  bit                exhausted;
  logic [CountW-1:0] found_count;

  bit                request_q [$];   // restart flag of each pending request
  nqse_res_t         awaited_rsp_q [$];
  nqse_res_t         head_rsp;
  int unsigned       req_gap;
  int unsigned       rsp_stall;
  int unsigned       bad_results;
  bit                no_idle;

  function automatic int unsigned board_dim();
    int unsigned n;
    n = size_q;
    if (n < 1) n = 1;
    if (n > MaxN) n = MaxN;
    return n;
  endfunction

  function automatic void clear_board();
    int unsigned r;
    cols_taken  = '0;
    sums_taken  = '0;
    diffs_taken = '0;
    for (r = 0; r < 16; r++) col_stack[r] = '0;
    rows_placed = 0;
    exhausted   = 1'b0;
    found_count = '0;
  endfunction

  function automatic void flip_queen(int unsigned n, int unsigned row, int unsigned col);
    cols_taken[col]            = ~cols_taken[col];
    sums_taken[row + col]      = ~sums_taken[row + col];
    diffs_taken[n - 1 + row - col] = ~diffs_taken[n - 1 + row - col];
  endfunction

  // Lift the queen of the last placed row; return the next column to try there
  function automatic int unsigned lift_queen(int unsigned n);
    int unsigned col;
    rows_placed--;
    col = col_stack[rows_placed];
    flip_queen(n, rows_placed, col);
    return col + 1;
  endfunction

  // Backtrack until a full board is placed; 0 when the search runs dry
  function automatic bit place_to_full(int unsigned n, int unsigned start_col);
    int unsigned col;
    int unsigned row;
    bit          placed;
    col = start_col;
    while (1) begin
      row    = rows_placed;
      placed = 1'b0;
      if (row >= n) return 1'b1;
      while (col < n && !placed) begin
        if (!cols_taken[col] && !sums_taken[row + col] && !diffs_taken[n - 1 + row - col]) begin
          flip_queen(n, row, col);
          col_stack[row] = col[3:0];
          rows_placed    = row + 1;
          placed         = 1'b1;
        end else begin
          col++;
        end
      end
      if (placed) col = 0;
      else if (row == 0) return 1'b0;
      else col = lift_queen(n);
    end
    return 1'b0;
  endfunction

  function automatic nqse_res_t next_solution(bit restart);
    nqse_res_t   res;
    int unsigned n;
    int unsigned col;
    int unsigned r;
    n   = board_dim();
    col = 0;
    res = '0;
    if (restart) clear_board();
    if (exhausted) begin
      res.solution_index = found_count;
      return res;
    end
    if (rows_placed >= n) col = lift_queen(n);
    if (!place_to_full(n, col)) begin
      exhausted          = 1'b1;
      res.solution_index = found_count;
      return res;
    end
    if (found_count != '1) found_count++;
    res.found = 1'b1;
    for (r = 0; r < n; r++) res.placement[4*r +: 4] = col_stack[r];
    res.solution_index = found_count;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_gap = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        awaited_rsp_q = {awaited_rsp_q, next_solution(req_if.restart)};
      end
      if (!req_if.valid || req_if.ready) begin
        if (req_gap > 0) begin
          req_gap--;
          req_if.valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          req_if.valid   <= 1'b1;
          req_if.restart <= request_q.pop_front();
          req_gap = pick_gap();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rsp_stall = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (awaited_rsp_q.size() == 0) begin
          if (bad_results < 10)
            $display("unexpected response: found=%0b placement=%h index=%0d",
                     rsp_if.found, rsp_if.placement, rsp_if.solution_index);
          bad_results++;
        end else begin
          head_rsp = awaited_rsp_q.pop_front();
          if (rsp_if.found !== head_rsp.found || rsp_if.placement !== head_rsp.placement ||
              rsp_if.solution_index !== head_rsp.solution_index) begin
            if (bad_results < 10)
              $display({"response mismatch: expected found=%0b placement=%h index=%0d,",
                        " got found=%0b placement=%h index=%0d"},
                       head_rsp.found, head_rsp.placement, head_rsp.solution_index,
                       rsp_if.found, rsp_if.placement, rsp_if.solution_index);
            bad_results++;
          end
        end
        rsp_stall = pick_gap();
      end else if (rsp_stall == 0 && !no_idle && $urandom_range(0, 31) == 0) begin
        rsp_stall = $urandom_range(1, 6);
      end
      if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Queue count requests; bit i of pattern is the restart flag of request i
  task automatic queue_requests(input int unsigned count, input logic [31:0] pattern);
    int unsigned i;
    for (i = 0; i < count; i++) request_q = {request_q, pattern[i]};
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (request_q.size() != 0 || req_if.valid || awaited_rsp_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_board_size(input logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    size_q = value;
    clear_board();
  endtask

  initial begin
    int unsigned     random_sent;
    int unsigned     batch;
    int unsigned     pick;
    logic [CfgW-1:0] size_val;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    req_if.valid   = 1'b0;
    req_if.restart = 1'b0;
    rsp_if.ready   = 1'b0;
    bad_results    = 0;
    no_idle        = 1'b0;
    size_q         = BoardSizeReset;
    clear_board();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Default 8x8 board: continue straight out of reset, then restart mid-search
    queue_requests(4, 32'b0100);
    wait_drained();
    // Size zero acts as a 1x1 board: one solution, then exhaustion that sticks until a restart
    write_board_size(5'd0);
    queue_requests(5, 32'b01000);
    wait_drained();
    // Sizes 2 and 3 have no solution at all
    write_board_size(5'd2);
    queue_requests(2, 32'b10);
    wait_drained();
    write_board_size(5'd3);
    queue_requests(2, 32'b01);
    wait_drained();
    write_board_size(5'd4);
    queue_requests(5, 32'b01000);
    wait_drained();
    // All-ones size clamps to the largest board and fills every placement nibble
    write_board_size(5'd31);
    queue_requests(2, 32'b01);
    wait_drained();
    write_board_size(5'd15);
    queue_requests(1, 32'b0);
    wait_drained();

    random_sent = 0;
    while (random_sent < 110) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) size_val = $urandom_range(0, 3);
      else if (pick < 85) size_val = $urandom_range(4, 8);
      else size_val = $urandom_range(9, 12);
      write_board_size(size_val);
      no_idle = ($urandom_range(0, 3) == 0);
      batch   = $urandom_range(4, 24);
      random_sent += batch;
      while (batch > 0) begin
        request_q = {request_q, ($urandom_range(0, 7) == 0)};
        batch--;
        // Hold off now and then until every response is back
        if (batch > 0 && $urandom_range(0, 15) == 0) wait_drained();
      end
      wait_drained();
    end

    no_idle = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (bad_results == 0 && awaited_rsp_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/nqse_pkg.sv
src/nqse_if.sv
src/nqse_ram.sv
src/nqse_engine.sv
src/n_queens_solution_enumerator_top.sv
src/nqse_checker.sv
sim/tb_n_queens_solution_enumerator_top.sv
